// ===== sv/sfr_pkg.sv =====
package sfr_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int REPLACE_MAX_DEF = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_LEN   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic append;
    logic rel_front;
    logic clear_held;
    logic repl_start;
    logic repl_emit;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic cnt_lt_plen;
    logic cnt_eq_plen;
    logic plen_zero;
    logic held_match;
    logic rlen_zero;
    logic repl_last;
    logic last;
    logic pend_valid;
    logic obuf_free;
  } sts_t;

endpackage

// ===== sv/sfr_ctrl.sv =====
module sfr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sfr_pkg::sts_t sts,
  output sfr_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_APPEND = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_REPL   = 3'd3;
  localparam logic [2:0] ST_END    = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       emit_ok;

  assign in_stall = (state_r != ST_IDLE);

  // a new result pushes the pending one into the output register
  assign emit_ok = !sts.pend_valid || sts.obuf_free;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_APPEND;
        end
      end
      ST_APPEND: begin
        if (sts.cnt_full) begin
          cmd.rel_front = emit_ok;
        end else begin
          cmd.append = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.cnt_zero) begin
          state_nxt = ST_END;
        end else if (!sts.plen_zero && sts.cnt_lt_plen) begin
          if (sts.held_match) begin
            state_nxt = ST_END;
          end else begin
            cmd.rel_front = emit_ok;
          end
        end else if (!sts.plen_zero && sts.cnt_eq_plen && sts.held_match) begin
          cmd.clear_held = 1'b1;
          if (!sts.rlen_zero) begin
            cmd.repl_start = 1'b1;
            state_nxt      = ST_REPL;
          end
        end else begin
          cmd.rel_front = emit_ok;
        end
      end
      ST_REPL: begin
        if (emit_ok) begin
          cmd.repl_emit = 1'b1;
          if (sts.repl_last) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_END: begin
        if (sts.last && !sts.cnt_zero) begin
          cmd.rel_front = emit_ok;
        end else if (sts.obuf_free || (!sts.pend_valid && !sts.last)) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/sfr_dpath.sv =====
module sfr_dpath #(
  parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]                     in_byte,
  input  logic                           in_string_end,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [7:0]                     out_byte,
  output logic                           out_out_valid,
  output logic                           out_result_end,
  output logic                           out_run_last,
  input  sfr_pkg::cmd_t                  cmd,
  output sfr_pkg::sts_t                  sts
);

  localparam int CNT_W  = $clog2(PATTERN_MAX + 1);
  localparam int HIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W  = sfr_pkg::LEN_W;

  logic [63:0]      pat_bytes_r;
  logic [LEN_W-1:0] pat_len_r;
  logic [63:0]      rep_bytes_r;
  logic [LEN_W-1:0] rep_len_r;

  logic [7:0]       held_r [PATTERN_MAX];
  logic [CNT_W-1:0] cnt_r;
  logic [7:0]       byte_r;
  logic             last_r;
  logic [2:0]       ridx_r;

  logic [7:0]       pend_byte_r;
  logic             pend_valid_r;

  logic             ovalid_r;
  logic [7:0]       obyte_r;
  logic             oov_r;
  logic             oend_r;
  logic             orun_r;

  logic [LEN_W-1:0] plen_eff;
  logic [LEN_W-1:0] rlen_eff;
  logic [LEN_W-1:0] cnt_ext;
  logic             held_match;
  logic             emit;
  logic [7:0]       emit_byte;
  logic [7:0]       rep_byte;
  logic             oload;
  logic [7:0]       oload_byte;
  logic             oload_ov;
  logic             oload_end;
  logic             oload_run;
  logic             obuf_free;

  // lengths above the build limits are clamped
  assign plen_eff = (pat_len_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_r;
  assign rlen_eff = (rep_len_r > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : rep_len_r;
  assign cnt_ext  = LEN_W'(cnt_r);

  // held bytes are a prefix of the pattern
  always_comb begin
    held_match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((LEN_W'(i) < cnt_ext) && (held_r[i] != pat_bytes_r[8*i +: 8])) begin
        held_match = 1'b0;
      end
    end
  end

  assign rep_byte  = rep_bytes_r[{ridx_r, 3'b000} +: 8];
  assign emit      = cmd.rel_front | cmd.repl_emit;
  assign emit_byte = cmd.rel_front ? held_r[0] : rep_byte;
  assign obuf_free = !ovalid_r || !out_stall;

  assign sts.cnt_zero    = (cnt_r == '0);
  assign sts.cnt_full    = (cnt_ext == LEN_W'(PATTERN_MAX));
  assign sts.cnt_lt_plen = (cnt_ext < plen_eff);
  assign sts.cnt_eq_plen = (cnt_ext == plen_eff);
  assign sts.plen_zero   = (plen_eff == '0);
  assign sts.held_match  = held_match;
  assign sts.rlen_zero   = (rlen_eff == '0);
  assign sts.repl_last   = ((LEN_W'(ridx_r) + LEN_W'(1)) == rlen_eff);
  assign sts.last        = last_r;
  assign sts.pend_valid  = pend_valid_r;
  assign sts.obuf_free   = obuf_free;

  // output register load: displaced pending result, or the closing one of a request
  always_comb begin
    oload      = 1'b0;
    oload_byte = pend_byte_r;
    oload_ov   = 1'b1;
    oload_end  = 1'b0;
    oload_run  = 1'b0;
    if (emit && pend_valid_r) begin
      oload = 1'b1;
    end else if (cmd.finish) begin
      if (pend_valid_r) begin
        oload     = 1'b1;
        oload_end = last_r;
        oload_run = 1'b1;
      end else if (last_r) begin
        // nothing to emit on the final byte: end marker only
        oload      = 1'b1;
        oload_byte = 8'd0;
        oload_ov   = 1'b0;
        oload_end  = 1'b1;
        oload_run  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= LEN_W'(1);
      rep_bytes_r <= '0;
      rep_len_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfr_pkg::CFG_PAT_BYTES: pat_bytes_r <= cfg_data[63:0];
        sfr_pkg::CFG_PAT_LEN:   pat_len_r   <= cfg_data[LEN_W-1:0];
        sfr_pkg::CFG_REP_BYTES: rep_bytes_r <= cfg_data[63:0];
        sfr_pkg::CFG_REP_LEN:   rep_len_r   <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rel_front) begin
      for (int k = 0; k < PATTERN_MAX - 1; k++) begin
        held_r[k] <= held_r[k+1];
      end
    end else if (cmd.append) begin
      held_r[cnt_r[HIDX_W-1:0]] <= byte_r;
    end
    if (cmd.capture) begin
      byte_r <= in_byte;
      last_r <= in_string_end;
    end
    if (cmd.repl_start) begin
      ridx_r <= 3'd0;
    end else if (cmd.repl_emit) begin
      ridx_r <= ridx_r + 3'd1;
    end
    if (emit) begin
      pend_byte_r <= emit_byte;
    end
    if (oload) begin
      obyte_r <= oload_byte;
      oov_r   <= oload_ov;
      oend_r  <= oload_end;
      orun_r  <= oload_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      ovalid_r     <= 1'b0;
    end else begin
      if (cmd.clear_held) begin
        cnt_r <= '0;
      end else if (cmd.rel_front) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end else if (cmd.append) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (emit) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid_r <= 1'b0;
      end
      if (oload) begin
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = ovalid_r;
  assign out_byte       = obyte_r;
  assign out_out_valid  = oov_r;
  assign out_result_end = oend_r;
  assign out_run_last   = orun_r;

endmodule

// ===== sv/stream_find_replace_core.sv =====
// Streaming find and replace, one source byte per request, one request at a time.
// Each request steps through IDLE, APPEND, SCAN and END; released bytes, replacement
//   bytes, matches and output stalls lengthen its stay. The closing result is presented
//   the cycle after END. A new request is taken only once the last is back in IDLE.
// Reset (rst_n, synchronous): no bytes held, pattern length 1, replacement length 0,
//   pattern and replacement bytes zero.
module stream_find_replace_core #(
  parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_byte,
  input  logic                           in_string_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_out_valid,
  output logic                           out_result_end,
  output logic                           out_run_last
);

  sfr_pkg::cmd_t cmd;
  sfr_pkg::sts_t sts;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfr_dpath #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_byte        (in_byte),
    .in_string_end  (in_string_end),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .out_out_valid  (out_out_valid),
    .out_result_end (out_result_end),
    .out_run_last   (out_run_last),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
